### src/crc8_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver
`ifndef CRC8_FRAME_RECEIVER_DEFINES_SVH
`define CRC8_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CRC8FR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication, checked out of reset
`define CRC8FR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

### src/crc8fr_pkg.sv
package crc8fr_pkg;

  // input item kinds
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // configuration register indexes
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  // result codes
  localparam logic [1:0] RES_GOOD       = 2'd0;
  localparam logic [1:0] RES_BAD_MARKER = 2'd1;
  localparam logic [1:0] RES_BAD_LENGTH = 2'd2;
  localparam logic [1:0] RES_BAD_CRC    = 2'd3;

  // CRC-8, reflected form
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic [7:0] command;
    logic [7:0] reply_status;
    logic [6:0] bytes_stored;
  } result_t;

  // one byte through the reflected CRC, bit by bit
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/crc8_frame_receiver.sv
// A result is valid on the master side in the cycle after its end request is taken.
// Throughput: one request per cycle; the core does all work for a byte combinationally
//   between registers (8-step CRC unrolled), so only a held result stalls end requests.
// Reset (rst, synchronous): clears markers, frame state and both valid flags.
`include "crc8_frame_receiver_defines.svh"

module crc8_frame_receiver #(
  parameter int BUF_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] command, [15:8] reply_status,
                                      // [22:16] bytes_stored, [23] zero
  output logic [1:0]  m_axis_tuser    // [1:0] result_code
);

  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic                 item_valid;
  crc8fr_pkg::in_item_t item;
  logic                 advance;
  logic                 out_free;
  logic                 result_load;
  crc8fr_pkg::result_t  result;
  logic [CW-1:0]        frame_count;

  // bytes always move on; an end request waits for a free result slot
  assign advance = item_valid && (item.action == crc8fr_pkg::ACT_BYTE || out_free);

  crc8fr_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  crc8fr_frame_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .advance     (advance),
    .item        (item),
    .result_load (result_load),
    .result      (result),
    .frame_count (frame_count)
  );

  crc8fr_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (result_load),
    .result        (result),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // a nonempty end request always produces a result next cycle
  `CRC8FR_ASSERT_NEXT(a_end_gives_result, advance && item.action == crc8fr_pkg::ACT_END && frame_count != '0, m_axis_tvalid && frame_count == '0)

  // a held item only stalls when it is an end request facing a blocked result
  `CRC8FR_ASSERT_NOW(a_stall_reason, item_valid && !advance, item.action == crc8fr_pkg::ACT_END && m_axis_tvalid && !m_axis_tready)

  // a stored byte bumps the count by one
  `CRC8FR_ASSERT_NEXT(a_count_step, advance && item.action == crc8fr_pkg::ACT_BYTE && frame_count < CW'(BUF_DEPTH), frame_count == $past(frame_count) + CW'(1))

  // a byte at a full buffer leaves the count alone
  `CRC8FR_ASSERT_NEXT(a_count_sat, advance && item.action == crc8fr_pkg::ACT_BYTE && frame_count == CW'(BUF_DEPTH), frame_count == CW'(BUF_DEPTH))

endmodule

### src/crc8fr_in_reg.sv
// Input register: holds one request until the frame core takes it
module crc8fr_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tuser,   // [0] action
  input  logic                 advance,
  output logic                 item_valid,
  output crc8fr_pkg::in_item_t item
);

  // room when empty or when the held item moves on this cycle
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.action    <= s_axis_tuser;
      item.data_byte <= s_axis_tdata;
    end
  end

endmodule

### src/crc8fr_frame_core.sv
// Frame state: markers, length, running CRC, command/status capture
module crc8fr_frame_core #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [7:0]           cfg_data,
  input  logic                 advance,
  input  crc8fr_pkg::in_item_t item,
  output logic                 result_load,
  output crc8fr_pkg::result_t  result,
  output logic [$clog2(BUF_DEPTH+1)-1:0] frame_count
);

  localparam int CW = $clog2(BUF_DEPTH + 1);
  // compare width: holds the count and an 8-bit length plus 4
  localparam int EW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [EW-1:0] DEPTH_E = EW'(BUF_DEPTH);

  logic [7:0] start_marker;
  logic [7:0] end_marker;

  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] last_byte, last_byte_next;
  logic [7:0] length_byte, length_byte_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] received_crc, received_crc_next;
  logic [7:0] command_byte, command_byte_next;
  logic [7:0] status_byte, status_byte_next;

  logic [EW-1:0] cnt_e;
  logic [EW-1:0] len_e;
  logic          is_end;

  assign cnt_e  = EW'(byte_count);
  assign len_e  = EW'(length_byte);
  assign is_end = (item.action == crc8fr_pkg::ACT_END);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= 8'd0;
      end_marker   <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        crc8fr_pkg::REG_START_MARKER: start_marker <= cfg_data;
        crc8fr_pkg::REG_END_MARKER:   end_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

  // next frame state
  always_comb begin
    byte_count_next   = byte_count;
    first_byte_next   = first_byte;
    last_byte_next    = last_byte;
    length_byte_next  = length_byte;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    command_byte_next = command_byte;
    status_byte_next  = status_byte;
    if (advance) begin
      if (is_end) begin
        // an empty frame clears to the same values it holds
        byte_count_next   = '0;
        first_byte_next   = 8'd0;
        last_byte_next    = 8'd0;
        length_byte_next  = 8'd0;
        running_crc_next  = crc8fr_pkg::CRC_INIT;
        received_crc_next = 8'd0;
        command_byte_next = 8'd0;
        status_byte_next  = 8'd0;
      end else if (cnt_e < DEPTH_E) begin
        if (cnt_e == EW'(0)) first_byte_next = item.data_byte;
        if (cnt_e == EW'(1)) length_byte_next = item.data_byte;
        if (cnt_e == EW'(2)) command_byte_next = item.data_byte;
        if (cnt_e == EW'(3)) status_byte_next = item.data_byte;
        if (cnt_e >= EW'(2)) begin
          if ((cnt_e - EW'(2)) < len_e) begin
            running_crc_next = crc8fr_pkg::crc8_update(running_crc, item.data_byte);
          end else if (cnt_e == (len_e + EW'(2))) begin
            received_crc_next = item.data_byte;
          end
        end
        last_byte_next  = item.data_byte;
        byte_count_next = CW'(cnt_e + EW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      first_byte   <= 8'd0;
      last_byte    <= 8'd0;
      length_byte  <= 8'd0;
      running_crc  <= crc8fr_pkg::CRC_INIT;
      received_crc <= 8'd0;
      command_byte <= 8'd0;
      status_byte  <= 8'd0;
    end else begin
      byte_count   <= byte_count_next;
      first_byte   <= first_byte_next;
      last_byte    <= last_byte_next;
      length_byte  <= length_byte_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
      command_byte <= command_byte_next;
      status_byte  <= status_byte_next;
    end
  end

  // frame checks, markers first, then length, then CRC
  always_comb begin
    priority if (first_byte != start_marker || last_byte != end_marker) begin
      result.result_code = crc8fr_pkg::RES_BAD_MARKER;
    end else if ((len_e + EW'(4)) != cnt_e) begin
      result.result_code = crc8fr_pkg::RES_BAD_LENGTH;
    end else if (running_crc != received_crc) begin
      result.result_code = crc8fr_pkg::RES_BAD_CRC;
    end else begin
      result.result_code = crc8fr_pkg::RES_GOOD;
    end
    result.command      = command_byte;
    result.reply_status = status_byte;
    result.bytes_stored = cnt_e[6:0];
  end

  assign result_load = advance && is_end && (byte_count != '0);
  assign frame_count = byte_count;

endmodule

### src/crc8fr_out_reg.sv
// Result register toward the master side
module crc8fr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  crc8fr_pkg::result_t result,
  output logic                out_free,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [7:0] command, [15:8] reply_status,
                                              // [22:16] bytes_stored, [23] zero
  output logic [1:0]          m_axis_tuser    // [1:0] result_code
);

  crc8fr_pkg::result_t held;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {1'b0, held.bytes_stored, held.reply_status, held.command};
  assign m_axis_tuser = held.result_code;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FRAME_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int PHASE_ITEMS   = 170;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 1000;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_FIXED
  } check_kind_t;

  typedef struct packed {
    logic                act;
    logic [7:0]          data;
    check_kind_t         chk;
    crc8fr_pkg::result_t fixed_res;
  } dir_row_t;

  localparam int DIRECTED_COUNT = 22;

  // markers are still at their reset value (0) for these rows
  localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // end with nothing stored: no result
    '{crc8fr_pkg::ACT_END,  8'h00, CHK_NONE,  '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    // minimal good frame: empty payload, CRC 0
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_END,  8'hFF, CHK_FIXED, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd4}},
    // one byte, wrong start: markers win over length
    '{crc8fr_pkg::ACT_BYTE, 8'hFF, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_END,  8'h00, CHK_FIXED,
      '{crc8fr_pkg::RES_BAD_MARKER, 8'h00, 8'h00, 7'd1}},
    // markers fine, too short for its length
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_END,  8'h00, CHK_FIXED,
      '{crc8fr_pkg::RES_BAD_LENGTH, 8'h00, 8'h00, 7'd2}},
    // one payload byte 0x80 (CRC 0x8C) sent with CRC byte 0x00
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h01, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h80, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_END,  8'h00, CHK_FIXED,
      '{crc8fr_pkg::RES_BAD_CRC, 8'h80, 8'h00, 7'd5}},
    // wrong end marker
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'h00, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_BYTE, 8'hFF, CHK_MODEL, '{crc8fr_pkg::RES_GOOD, 8'h00, 8'h00, 7'd0}},
    '{crc8fr_pkg::ACT_END,  8'h00, CHK_FIXED,
      '{crc8fr_pkg::RES_BAD_MARKER, 8'h00, 8'hFF, 7'd4}}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = crc8fr_pkg::REG_START_MARKER;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;                  // [7:0] data_byte
  logic        s_axis_tuser = crc8fr_pkg::ACT_BYTE;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] command, [15:8] reply_status,
                                       // [22:16] bytes_stored, [23] zero
  logic [1:0]  m_axis_tuser;           // [1:0] result_code

  crc8_frame_receiver #(
    .BUF_DEPTH(FRAME_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // frame tracker state, mirrors the block
  logic [7:0] start_mark = 8'h00;
  logic [7:0] end_mark   = 8'h00;
  int         frame_count = 0;
  logic [7:0] frame_first = 8'h00;
  logic [7:0] frame_last  = 8'h00;
  logic [7:0] frame_len   = 8'h00;
  logic [7:0] crc_acc     = crc8fr_pkg::CRC_INIT;
  logic [7:0] crc_rx      = 8'h00;
  logic [7:0] cmd_byte    = 8'h00;
  logic [7:0] stat_byte   = 8'h00;

  crc8fr_pkg::result_t pending_results[$];
  int      failures = 0;
  int      n_requests = 0;
  int      n_results = 0;
  int      code_seen [4] = '{0, 0, 0, 0};
  int      n_settings = 1;
  int      send_calm = 0;
  int      recv_calm = 0;
  int      idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // reflected CRC-8, one input bit at a time, LSB first
  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ b[k];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ crc8fr_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  // advance the frame tracker by one request; returns 1 when a result is due
  function automatic bit frame_step(input logic act, input logic [7:0] b,
                                    output crc8fr_pkg::result_t res);
    res = '0;
    if (act == crc8fr_pkg::ACT_BYTE) begin
      // full buffer: byte dropped, count stays
      if (frame_count >= FRAME_DEPTH) begin
        return 1'b0;
      end
      unique case (frame_count)
        0: frame_first = b;
        1: frame_len   = b;
        2: cmd_byte    = b;
        3: stat_byte   = b;
        default: ;
      endcase
      if (frame_count >= 2) begin
        if (frame_count - 2 < int'(frame_len)) begin
          crc_acc = crc8_shift(crc_acc, b);
        end else if (frame_count == int'(frame_len) + 2) begin
          crc_rx = b;
        end
      end
      frame_last  = b;
      frame_count = frame_count + 1;
      return 1'b0;
    end
    if (frame_count == 0) begin
      return 1'b0;
    end
    // markers first, then length, then CRC
    if (frame_first != start_mark || frame_last != end_mark) begin
      res.result_code = crc8fr_pkg::RES_BAD_MARKER;
    end else if (int'(frame_len) + 4 != frame_count) begin
      res.result_code = crc8fr_pkg::RES_BAD_LENGTH;
    end else if (crc_acc != crc_rx) begin
      res.result_code = crc8fr_pkg::RES_BAD_CRC;
    end else begin
      res.result_code = crc8fr_pkg::RES_GOOD;
    end
    res.command      = cmd_byte;
    res.reply_status = stat_byte;
    res.bytes_stored = 7'(frame_count);
    frame_count = 0;
    frame_first = 8'h00;
    frame_last  = 8'h00;
    frame_len   = 8'h00;
    crc_acc     = crc8fr_pkg::CRC_INIT;
    crc_rx      = 8'h00;
    cmd_byte    = 8'h00;
    stat_byte   = 8'h00;
    return 1'b1;
  endfunction

  // idle length for one item; now and then a calm stretch with no idling
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 40);
    end
    return $urandom_range(0, 10);
  endfunction

  // drive one request, wait for its handshake, then log what it should produce
  task automatic send_req(input logic act, input logic [7:0] b,
                          input check_kind_t chk, input crc8fr_pkg::result_t fixed_res);
    int                  gap;
    crc8fr_pkg::result_t want;
    bit                  due;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    n_requests = n_requests + 1;
    due = frame_step(act, b, want);
    if (chk == CHK_FIXED) begin
      pending_results.push_back(fixed_res);
    end else if (chk == CHK_MODEL && due) begin
      pending_results.push_back(want);
    end
  endtask

  // drain the block, then let it go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both marker registers in back-to-back writes
  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_we   <= 1'b1;
    cfg_addr <= crc8fr_pkg::REG_START_MARKER;
    cfg_data <= s;
    @(posedge clk);
    cfg_addr <= crc8fr_pkg::REG_END_MARKER;
    cfg_data <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_mark = s;
    end_mark   = e;
  endtask

  // stimulus
  initial begin
    logic [7:0] frame_bytes[$];
    logic [7:0] crc;
    logic [7:0] b;
    int         kind;
    int         plen;
    int         pos;
    int         ph;
    int         phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_req(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].data,
               DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].fixed_res);
    end

    ph = 0;
    while (n_requests < DIRECTED_COUNT + RANDOM_ITEMS) begin
      settle();
      unique case (ph)
        0: set_markers(8'hFF, 8'hFF);
        1: set_markers(8'h00, 8'hFF);
        2: set_markers(8'hFF, 8'h00);
        3: set_markers(8'h00, 8'h00);
        default: set_markers(8'($urandom), 8'($urandom));
      endcase
      n_settings = n_settings + 1;
      ph = ph + 1;
      phase_start = n_requests;
      while (n_requests - phase_start < PHASE_ITEMS &&
             n_requests < DIRECTED_COUNT + RANDOM_ITEMS) begin
        kind = $urandom_range(0, 19);
        frame_bytes.delete();
        if (kind <= 14 || kind == 19) begin
          // well-formed frame, mostly short payloads
          plen = (kind == 19) ? $urandom_range(40, 60) : $urandom_range(0, 6);
          crc  = crc8fr_pkg::CRC_INIT;
          frame_bytes.push_back(start_mark);
          frame_bytes.push_back(8'(plen));
          repeat (plen) begin
            b   = 8'($urandom);
            crc = crc8_shift(crc, b);
            frame_bytes.push_back(b);
          end
          frame_bytes.push_back(crc);
          frame_bytes.push_back(end_mark);
          // broken copy: flip one byte or slip in an extra one
          if (kind >= 12 && kind <= 14) begin
            if ($urandom_range(0, 1) == 1) begin
              pos = $urandom_range(0, frame_bytes.size() - 1);
              frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
            end else begin
              frame_bytes.insert($urandom_range(2, frame_bytes.size() - 1), 8'($urandom));
            end
          end
        end else if (kind <= 16) begin
          // line noise
          repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
        end else if (kind == 17) begin
          // runs past the buffer
          frame_bytes.push_back(start_mark);
          repeat ($urandom_range(64, 71)) frame_bytes.push_back(8'($urandom));
          if ($urandom_range(0, 1) == 1) begin
            frame_bytes[FRAME_DEPTH - 1] = end_mark;
          end
        end
        // kind 18 leaves the frame empty: a lone end request
        foreach (frame_bytes[i]) begin
          send_req(crc8fr_pkg::ACT_BYTE, frame_bytes[i], CHK_MODEL, '0);
        end
        send_req(crc8fr_pkg::ACT_END, 8'($urandom), CHK_MODEL, '0);
      end
    end

    settle();
    $display("Covered %0d requests over %0d marker settings, %0d results checked",
             n_requests, n_settings, n_results);
    $display("  good %0d, bad marker %0d, bad length %0d, bad CRC %0d",
             code_seen[crc8fr_pkg::RES_GOOD], code_seen[crc8fr_pkg::RES_BAD_MARKER],
             code_seen[crc8fr_pkg::RES_BAD_LENGTH], code_seen[crc8fr_pkg::RES_BAD_CRC]);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int                  stall;
    crc8fr_pkg::result_t got;
    crc8fr_pkg::result_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.result_code  = m_axis_tuser;
      got.command      = m_axis_tdata[7:0];
      got.reply_status = m_axis_tdata[15:8];
      got.bytes_stored = m_axis_tdata[22:16];
      n_results = n_results + 1;
      code_seen[got.result_code] = code_seen[got.result_code] + 1;
      if (pending_results.size() == 0) begin
        failures = failures + 1;
        $display("%0t: unexpected result code %0d cmd %h status %h count %0d",
                 $realtime, got.result_code, got.command, got.reply_status,
                 got.bytes_stored);
      end else begin
        want = pending_results.pop_front();
        if (got.result_code !== want.result_code || got.command !== want.command ||
            got.reply_status !== want.reply_status ||
            got.bytes_stored !== want.bytes_stored) begin
          failures = failures + 1;
          $display("%0t: expected code %0d cmd %h status %h count %0d",
                   $realtime, want.result_code, want.command, want.reply_status,
                   want.bytes_stored);
          $display("%0t:   actual code %0d cmd %h status %h count %0d",
                   $realtime, got.result_code, got.command, got.reply_status,
                   got.bytes_stored);
        end
      end
    end
  end

  // watchdog: too long with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $realtime, idle_cycles, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+src
src/crc8fr_pkg.sv
src/crc8fr_in_reg.sv
src/crc8fr_frame_core.sv
src/crc8fr_out_reg.sv
src/crc8_frame_receiver.sv
verif/testbench.sv
